FILE: rtl/ffd_pkg.sv
// Shared types, register codes and constants of the frame flash detector.
package ffd_pkg;

  localparam int FFD_PIXELS = 1024;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_FLASHES  = 2'd0,
    CFG_FRACTION_DIV = 2'd1,
    CFG_COLOUR_DIST  = 2'd2,
    CFG_LUMA_DIST    = 2'd3
  } cfg_index_t;

  localparam logic [7:0]  RST_MAX_FLASHES  = 8'd3;
  localparam logic [10:0] RST_FRACTION_DIV = 11'd5;
  localparam logic [9:0]  RST_COLOUR_DIST  = 10'd250;
  localparam logic [7:0]  RST_LUMA_DIST    = 8'd75;

  typedef enum logic {
    OP_PIXEL  = 1'b0,
    OP_WINDOW = 1'b1
  } opcode_t;

  typedef enum logic {
    VK_FRAME  = 1'b0,
    VK_WINDOW = 1'b1
  } verdict_kind_t;

  localparam logic [10:0] CHANGED_MAX = 11'd2047;
  localparam logic [7:0]  FLASH_MAX   = 8'd255;

  // Luminance weights scaled by 65536; they sum to exactly 65536.
  localparam logic [23:0] LUMA_R = 24'd13933;
  localparam logic [23:0] LUMA_G = 24'd46871;
  localparam logic [23:0] LUMA_B = 24'd4732;

  localparam logic [9:0] RM_RED_BASE  = 10'd512;
  localparam logic [9:0] RM_BLUE_BASE = 10'd767;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SQUARE   = 6'b000010,
    ST_MULTIPLY = 6'b000100,
    ST_COMPARE  = 6'b001000,
    ST_FRAME    = 6'b010000,
    ST_WINDOW   = 6'b100000
  } state_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic multiply;
    logic compare;
    logic emit_frame;
    logic emit_window;
  } ffd_cmd_t;

  typedef struct packed {
    logic is_window;
    logic last;
    logic out_free;
  } ffd_status_t;

  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [23:0] sum;
    sum = LUMA_R * 24'(r) + LUMA_G * 24'(g) + LUMA_B * 24'(b);
    return sum[23:16];
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

endpackage

FILE: rtl/ffd_ctrl.sv
// Sequencer that steps each transaction through the pixel compare or the window verdict.
module ffd_ctrl
  import ffd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ffd_status_t status,
  output ffd_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        // The stored pixel was read at capture; window transactions skip the compare.
        if (status.is_window) begin
          state_next = ST_WINDOW;
        end else begin
          cmd.square = 1'b1;
          state_next = ST_MULTIPLY;
        end
      end
      ST_MULTIPLY: begin
        cmd.multiply = 1'b1;
        state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next = status.last ? ST_FRAME : ST_IDLE;
      end
      ST_FRAME: begin
        if (status.out_free) begin
          cmd.emit_frame = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WINDOW: begin
        if (status.out_free) begin
          cmd.emit_window = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ffd_datapath.sv
// Frame store, colour and luminance compare, counters and the output register.
module ffd_datapath
  import ffd_pkg::*;
#(
  parameter int PIXELS = FFD_PIXELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ffd_cmd_t               cmd,
  output ffd_status_t            status,
  input  logic [23:0]            in_data,
  input  logic                   in_last,
  input  logic                   in_user,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [23:0]            out_data,
  output logic                   out_user
);

  localparam int PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [PW-1:0] PosLast  = PW'(PIXELS - 1);
  localparam logic [22:0]   PixLimit = 23'(PIXELS);

  // Configuration registers.
  logic [7:0]  max_flashes;
  logic [10:0] fraction_div;
  logic [9:0]  colour_dist;
  logic [7:0]  luma_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_flashes  <= RST_MAX_FLASHES;
      fraction_div <= RST_FRACTION_DIV;
      colour_dist  <= RST_COLOUR_DIST;
      luma_dist    <= RST_LUMA_DIST;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_FLASHES:  max_flashes  <= cfg_data[7:0];
        CFG_FRACTION_DIV: fraction_div <= cfg_data;
        CFG_COLOUR_DIST:  colour_dist  <= cfg_data[9:0];
        CFG_LUMA_DIST:    luma_dist    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Captured transaction.
  logic [7:0] cur_r, cur_g, cur_b;
  logic       cur_last;
  logic       cur_op;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r    <= in_data[7:0];
      cur_g    <= in_data[15:8];
      cur_b    <= in_data[23:16];
      cur_last <= in_last;
      cur_op   <= in_user;
    end
  end

  // Frame store: read at capture, written back in the compare step.
  logic [23:0]   mem [PIXELS];
  logic [23:0]   old_q;
  logic [PW-1:0] pos;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      old_q <= mem[pos];
    end
    if (cmd.compare) begin
      mem[pos] <= {cur_b, cur_g, cur_r};
    end
  end

  logic [7:0] old_r, old_g, old_b;
  assign old_r = old_q[7:0];
  assign old_g = old_q[15:8];
  assign old_b = old_q[23:16];

  // Square step: differences, squares and both luminances.
  logic [8:0]  rgb_sum;
  logic [7:0]  dr, dg, db;
  logic [7:0]  rm_q;
  logic [15:0] dr2_q, dg2_q, db2_q;
  logic [7:0]  y_cur_q, y_old_q;

  assign rgb_sum = 9'(cur_r) + 9'(old_r);
  assign dr = abs_diff(cur_r, old_r);
  assign dg = abs_diff(cur_g, old_g);
  assign db = abs_diff(cur_b, old_b);

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      rm_q    <= rgb_sum[8:1];
      dr2_q   <= 16'(dr) * 16'(dr);
      dg2_q   <= 16'(dg) * 16'(dg);
      db2_q   <= 16'(db) * 16'(db);
      y_cur_q <= luma(cur_r, cur_g, cur_b);
      y_old_q <= luma(old_r, old_g, old_b);
    end
  end

  // Multiply step: weighted redmean terms and the squared limit.
  logic [25:0] prod_r, prod_b;
  logic [10:0] lim;
  logic [17:0] term_r_q, term_g_q, term_b_q;
  logic [21:0] lim_sq_q;
  logic [7:0]  dy_q;

  assign prod_r = 26'(RM_RED_BASE + 10'(rm_q)) * 26'(dr2_q);
  assign prod_b = 26'(RM_BLUE_BASE - 10'(rm_q)) * 26'(db2_q);
  assign lim    = 11'(colour_dist) + 11'd1;

  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      term_r_q <= prod_r[25:8];
      term_g_q <= {dg2_q, 2'b00};
      term_b_q <= prod_b[25:8];
      lim_sq_q <= 22'(lim) * 22'(lim);
      dy_q     <= abs_diff(y_cur_q, y_old_q);
    end
  end

  // Compare step and frame/window bookkeeping.
  logic [19:0] dist_sq;
  logic        pix_changed;
  logic        have_prev;
  logic [10:0] changed_count;
  logic [7:0]  flash_frames;
  logic        danger_flag;

  assign dist_sq = 20'(term_r_q) + 20'(term_g_q) + 20'(term_b_q);
  assign pix_changed = (22'(dist_sq) >= lim_sq_q) || (dy_q >= luma_dist);

  // changed > PIXELS / div holds exactly when changed * div > PIXELS.
  logic [10:0] eff_div;
  logic [21:0] frac_prod;
  logic        frame_flashed;
  logic [7:0]  flash_next;

  assign eff_div = (fraction_div == 11'd0) ? 11'd1 : fraction_div;
  assign frac_prod = 22'(changed_count) * 22'(eff_div);
  assign frame_flashed = have_prev && (23'(frac_prod) > PixLimit);
  assign flash_next = (frame_flashed && flash_frames != FLASH_MAX) ?
                      flash_frames + 8'd1 : flash_frames;

  logic danger_hit;
  assign danger_hit = (flash_frames >> 1) >= max_flashes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      have_prev     <= 1'b0;
      changed_count <= '0;
      flash_frames  <= '0;
      danger_flag   <= 1'b0;
    end else begin
      if (cmd.compare) begin
        if (have_prev && pix_changed && changed_count != CHANGED_MAX) begin
          changed_count <= changed_count + 11'd1;
        end
        pos <= (pos == PosLast) ? '0 : pos + PW'(1);
      end
      if (cmd.emit_frame) begin
        flash_frames  <= flash_next;
        have_prev     <= 1'b1;
        pos           <= '0;
        changed_count <= '0;
      end
      if (cmd.emit_window) begin
        flash_frames <= '0;
        danger_flag  <= danger_hit;
      end
    end
  end

  // Output register; a new verdict may load in the cycle the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_frame || cmd.emit_window) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_frame) begin
      out_user <= VK_FRAME;
      out_data <= {2'b00, 1'b0, danger_flag, flash_next, changed_count, frame_flashed};
    end else if (cmd.emit_window) begin
      out_user <= VK_WINDOW;
      out_data <= {2'b00, danger_hit != danger_flag, danger_hit, flash_frames,
                   11'd0, 1'b0};
    end
  end

  assign status.is_window = (cur_op == OP_WINDOW);
  assign status.last      = cur_last;
  assign status.out_free  = !out_valid || out_ready;

endmodule

FILE: rtl/frame_flash_detector.sv
// Top level of the frame flash detector: stream ports, configuration port, controller and datapath.
// A pixel transaction steps through store read, square, multiply and compare before the next
// ready; the last pixel of a frame adds a step for the frame verdict.
// A window transaction steps through capture, dispatch and verdict. Verdicts leave through a
// one-entry output register, so a waiting verdict only holds the controller when the next is due.
// Synchronous reset restores the register defaults and clears counters, flags and the
// position; the frame store is not cleared, and the first frame after reset only fills it.
module frame_flash_detector
  import ffd_pkg::*;
#(
  parameter int PIXELS = FFD_PIXELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  input  logic                   s_axis_tlast,
  input  logic                   s_axis_tuser,  // opcode [0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // frame_flashed [0], changed_pixels [11:1], window_flash_count [19:12], danger [20],
  // danger_changed [21], zero [23:22]
  output logic [23:0]            m_axis_tdata,
  output logic                   m_axis_tuser,  // verdict_kind [0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ffd_cmd_t    cmd;
  ffd_status_t status;

  assign cfg_ready = 1'b1;

  ffd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ffd_datapath #(
    .PIXELS (PIXELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .in_user   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

FILE: tb/tb_frame_flash_detector.sv
`timescale 1ns / 100ps
// Self-checking testbench of frame_flash_detector: pixel and window streams against a scoreboard.
module tb_frame_flash_detector;
  import ffd_pkg::*;

  localparam int TAIL_CYCLES = 16;
  localparam int PHASE_ITEMS = 70;
  // No later frame may be longer than the first one, so every stored pixel read was written.
  localparam int FIRST_FRAME_LEN = 64;

  typedef struct {
    verdict_kind_t kind;
    logic          flashed;
    logic [10:0]   changed;
    logic [7:0]    count;
    logic          danger;
    logic          toggled;
  } verdict_t;

  class flash_scoreboard;
    logic [7:0]  max_flashes;
    logic [10:0] fraction_div;
    logic [9:0]  colour_limit;
    logic [7:0]  luma_limit;
    logic [23:0] frame_store [FFD_PIXELS];
    bit          have_prev;
    int unsigned pixel_pos;
    logic [10:0] changed_run;
    logic [7:0]  flash_run;
    bit          danger_state;
    verdict_t    pending_verdicts [$];
    int          errors;

    function new();
      max_flashes = 8'd3;
      fraction_div = 11'd5;
      colour_limit = 10'd250;
      luma_limit = 8'd75;
      have_prev = 0;
      pixel_pos = 0;
      changed_run = '0;
      flash_run = '0;
      danger_state = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [10:0] value);
      case (idx)
        CFG_MAX_FLASHES:  max_flashes = value[7:0];
        CFG_FRACTION_DIV: fraction_div = value;
        CFG_COLOUR_DIST:  colour_limit = value[9:0];
        CFG_LUMA_DIST:    luma_limit = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned brightness(int unsigned r, int unsigned g, int unsigned b);
      return (32'd13933 * r + 32'd46871 * g + 32'd4732 * b) >> 16;
    endfunction

    function int unsigned gap(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Redmean distance is compared in the squared domain, so no root is needed.
    function bit pixel_moved(logic [23:0] now_rgb, logic [23:0] old_rgb);
      int unsigned r1, g1, b1, r0, g0, b0, mean, dr, dg, db, dist_sq, bound, dy;
      r1 = now_rgb[23:16];
      g1 = now_rgb[15:8];
      b1 = now_rgb[7:0];
      r0 = old_rgb[23:16];
      g0 = old_rgb[15:8];
      b0 = old_rgb[7:0];
      mean = (r1 + r0) >> 1;
      dr = gap(r1, r0);
      dg = gap(g1, g0);
      db = gap(b1, b0);
      dist_sq = (((32'd512 + mean) * dr * dr) >> 8) + 32'd4 * dg * dg
              + (((32'd767 - mean) * db * db) >> 8);
      bound = colour_limit + 32'd1;
      dy = gap(brightness(r1, g1, b1), brightness(r0, g0, b0));
      return (dist_sq >= bound * bound) || (dy >= luma_limit);
    endfunction

    function void accept_item(opcode_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic last);
      verdict_t    v;
      int unsigned slot;
      int unsigned divisor;
      v.kind = VK_FRAME;
      v.flashed = 1'b0;
      v.changed = '0;
      v.toggled = 1'b0;
      if (op == OP_WINDOW) begin
        v.kind = VK_WINDOW;
        v.count = flash_run;
        if ((flash_run >> 1) >= max_flashes) begin
          if (!danger_state) begin
            danger_state = 1;
            v.toggled = 1'b1;
          end
        end else if (danger_state) begin
          danger_state = 0;
          v.toggled = 1'b1;
        end
        v.danger = danger_state;
        flash_run = '0;
        pending_verdicts.push_back(v);
        return;
      end
      slot = pixel_pos;
      if (have_prev && pixel_moved({r, g, b}, frame_store[slot]) && changed_run != 11'd2047)
        changed_run++;
      frame_store[slot] = {r, g, b};
      pixel_pos = (slot == FFD_PIXELS - 1) ? 0 : slot + 1;
      if (!last) return;
      divisor = (fraction_div == 0) ? 1 : fraction_div;
      if (have_prev && changed_run > FFD_PIXELS / divisor) begin
        v.flashed = 1'b1;
        if (flash_run != 8'd255) flash_run++;
      end
      v.changed = changed_run;
      v.count = flash_run;
      v.danger = danger_state;
      pending_verdicts.push_back(v);
      have_prev = 1;
      pixel_pos = 0;
      changed_run = '0;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic [23:0] data, logic user);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("verdict with none expected: tuser %b tdata %h", user, data);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      compare_field("verdict_kind", v.kind, user);
      compare_field("frame_flashed", v.flashed, data[0]);
      compare_field("changed_pixels", v.changed, data[11:1]);
      compare_field("window_flash_count", v.count, data[19:12]);
      compare_field("danger", v.danger, data[20]);
      compare_field("danger_changed", v.toggled, data[21]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  flash_scoreboard sb = new();
  int src_idle = 8;
  int sink_stall = 82;
  int items_sent = 0;

  frame_flash_detector uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      sb.check_verdict(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    #2_000_000;
    $display("tb_frame_flash_detector: done, errors");
    $finish;
  end

  // Entered and left at a falling edge; valid stays high into the next call unless it idles.
  task automatic send_item(opcode_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic last);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    s_axis_tlast <= last;
    s_axis_tuser <= op;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.accept_item(op, r, g, b, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [23:0] rgb, logic last);
    send_item(OP_PIXEL, rgb[23:16], rgb[15:8], rgb[7:0], last);
  endtask

  task automatic send_window();
    send_item(OP_WINDOW, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // A pixel still in flight after the last verdict may not yet be done, hence the tail.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [10:0] flashes, logic [10:0] divisor,
                               logic [10:0] colour, logic [10:0] luma_lim);
    write_reg(CFG_MAX_FLASHES, flashes);
    write_reg(CFG_FRACTION_DIV, divisor);
    write_reg(CFG_COLOUR_DIST, colour);
    write_reg(CFG_LUMA_DIST, luma_lim);
  endtask

  function automatic logic [7:0] nudge(logic [7:0] v);
    int x;
    x = int'(v) + int'($urandom_range(0, 40)) - 20;
    return (x < 0) ? 8'd0 : (x > 255) ? 8'd255 : 8'(x);
  endfunction

  // Half the colours are at or near the stored pixel, so the thresholds are hit from both sides.
  function automatic logic [23:0] pick_colour();
    logic [23:0] old;
    old = sb.frame_store[sb.pixel_pos];
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return {nudge(old[23:16]), nudge(old[15:8]), nudge(old[7:0])};
      2: return {($urandom_range(0, 1) ? 8'hFF : 8'h00), ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                 ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      default: return old;
    endcase
  endfunction

  task automatic random_frame();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_window();
      send_pixel(pick_colour(), i == len - 1);
    end
  endtask

  logic [10:0] setting [6][4] = '{
    '{11'd0,   11'd1024, 11'd0,    11'd0},
    '{11'd255, 11'd1,    11'd1023, 11'd255},
    '{11'd1,   11'd0,    11'd120,  11'd30},
    '{11'd2,   11'd2047, 11'd300,  11'd60},
    '{11'd1,   11'd64,   11'd200,  11'd40},
    '{11'd0,   11'd0,    11'd0,    11'd0}
  };

  initial begin
    int start;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults; the first frame fills every position that later frames use
    // and gives a bare verdict.
    send_window();
    for (int p = 0; p < FIRST_FRAME_LEN; p++) begin
      if (p == FIRST_FRAME_LEN / 2) send_window();
      send_pixel(24'($urandom), p == FIRST_FRAME_LEN - 1);
    end
    for (int rep = 0; rep < 2; rep++) begin
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0);
      send_window();
      send_pixel(24'hFF0000, 1'b0);
      send_pixel(24'h00FF00, 1'b0);
      send_pixel(24'h0000FF, 1'b1);
    end
    send_pixel(24'hFFFFFF, 1'b1);
    send_window();
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      src_idle = (ph < 2) ? 8 : (ph < 4) ? 82 : 0;
      sink_stall = (ph < 2) ? 82 : (ph < 4) ? 8 : 0;
      if (ph == 5)
        apply_setting(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
      else
        apply_setting(setting[ph][0], setting[ph][1], setting[ph][2], setting[ph][3]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) random_frame();
      if ($urandom_range(0, 1)) send_window();
      settle();
    end

    // Every pixel counts as changed and a single changed pixel makes a flash here, so
    // one-pixel frames saturate the window count.
    apply_setting(11'd127, 11'd2047, 11'd0, 11'd0);
    for (int f = 0; f < 260; f++) send_pixel(24'($urandom), 1'b1);
    send_window();
    send_window();
    settle();

    if (sb.errors == 0)
      $display("tb_frame_flash_detector: done, clean");
    else
      $display("tb_frame_flash_detector: done, errors");
    $finish;
  end

endmodule
